// ----- rtl/acclt_pkg.sv -----
// Shared types and constants for the accelerometer low-pass tilt-angle unit.
// No dependencies.
package acclt_pkg;

  localparam int ALPHA_W      = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd49709;
  localparam int CORDIC_STEPS = 23;
  localparam int STEP_W       = 5;
  localparam int Z_W          = 25;
  localparam int ANGLE_W      = 16;
  localparam logic signed [16:0] INV_GAIN_Q16 = 17'sd39797;
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;

  // register index codes
  localparam logic REG_ALPHA = 1'b0;

  // atan(2^-i) in 2^-16 degree
  localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_FMUL, ST_FUPD, ST_MINIT, ST_MAG, ST_GMUL, ST_AINIT, ST_ANG, ST_OUT
  } state_t;

  typedef struct packed {
    logic              load_in;
    logic              fmul;
    logic              fupd;
    logic              minit;
    logic              mstep;
    logic              gmul;
    logic              ainit;
    logic              astep;
    logic              oload;
    logic [STEP_W-1:0] step;
  } cmd_t;

endpackage

// ----- rtl/accel_lowpass_tilt_angles_unit.sv -----
// Top level of the accelerometer low-pass tilt-angle unit.
// Depends on acclt_pkg, acclt_ctrl and acclt_datapath.
//
// Use:
//   Input channel (in_valid/in_ready) carries one 3-axis sample per transfer.
//   Each axis runs through an exponential low-pass y += alpha*(x - y), with
//   alpha written over the APB port (register 0, address 0, Q0.16).
//   Output channel (out_valid/out_ready) carries the three rounded gravity
//   values and the three tilt angles in 1/256 degree.
// Sequence:
//   After an input transfer, one sample runs through filter multiply, filter
//   update, CORDIC setup, 23 magnitude iterations, gain multiply, angle setup,
//   23 angle iterations and the output load, one step per cycle (the output
//   load waits while the output register is full), all three axes in
//   parallel lanes. A new sample is taken only back in idle, after the load.
//   in_ready is high only while the sequencer is idle. The finished result
//   sits in an output register, so a new sample is taken while it waits.
// Reset (synchronous, rst_n low): filter state cleared to zero, alpha back to
//   49709, sequencer idle, out_valid low.
// Stall: if out_ready stays low, the next result waits in the last sequencer
//   state until the output register frees up; nothing is dropped.
module accel_lowpass_tilt_angles_unit #(
  parameter int SAMPLE_BITS   = 14,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_x,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_y,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_gravity_x,
  output logic signed [SAMPLE_BITS-1:0]        out_gravity_y,
  output logic signed [SAMPLE_BITS-1:0]        out_gravity_z,
  output logic signed [acclt_pkg::ANGLE_W-1:0] out_angle_x,
  output logic signed [acclt_pkg::ANGLE_W-1:0] out_angle_y,
  output logic signed [acclt_pkg::ANGLE_W-1:0] out_angle_z,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  acclt_pkg::cmd_t cmd;
  logic [acclt_pkg::ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic dp_ok;

  // config register: written on the access phase of an APB write
  always_comb begin
    alpha_nxt = alpha_r;
    if (psel && penable && pwrite && (paddr[2] == acclt_pkg::REG_ALPHA))
      alpha_nxt = pwdata[acclt_pkg::ALPHA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= acclt_pkg::ALPHA_RESET;
    end else begin
      alpha_r <= alpha_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == acclt_pkg::REG_ALPHA && dp_ok)
                  ? {{(32-acclt_pkg::ALPHA_W){1'b0}}, alpha_r} : '0;

  acclt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  acclt_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .alpha         (alpha_r),
    .in_sample_x   (in_sample_x),
    .in_sample_y   (in_sample_y),
    .in_sample_z   (in_sample_z),
    .out_gravity_x (out_gravity_x),
    .out_gravity_y (out_gravity_y),
    .out_gravity_z (out_gravity_z),
    .out_angle_x   (out_angle_x),
    .out_angle_y   (out_angle_y),
    .out_angle_z   (out_angle_z),
    .unused_ok     (dp_ok)
  );

endmodule

// ----- rtl/acclt_ctrl.sv -----
// Sequencer for the tilt-angle unit: steps the datapath through filter and CORDIC.
// Depends on acclt_pkg.
module acclt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output acclt_pkg::cmd_t   cmd
);

  acclt_pkg::state_t state_r, state_nxt;
  logic [acclt_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  localparam logic [acclt_pkg::STEP_W-1:0] LAST_STEP =
    acclt_pkg::STEP_W'(acclt_pkg::CORDIC_STEPS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acclt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.step  = cnt_r;
    in_ready  = 1'b0;
    unique case (state_r)
      acclt_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = acclt_pkg::ST_FMUL;
      end
      acclt_pkg::ST_FMUL: begin
        cmd.fmul  = 1'b1;
        state_nxt = acclt_pkg::ST_FUPD;
      end
      acclt_pkg::ST_FUPD: begin
        cmd.fupd  = 1'b1;
        state_nxt = acclt_pkg::ST_MINIT;
      end
      acclt_pkg::ST_MINIT: begin
        cmd.minit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = acclt_pkg::ST_MAG;
      end
      acclt_pkg::ST_MAG: begin
        cmd.mstep = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          cnt_nxt   = '0;
          state_nxt = acclt_pkg::ST_GMUL;
        end
      end
      acclt_pkg::ST_GMUL: begin
        cmd.gmul  = 1'b1;
        state_nxt = acclt_pkg::ST_AINIT;
      end
      acclt_pkg::ST_AINIT: begin
        cmd.ainit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = acclt_pkg::ST_ANG;
      end
      acclt_pkg::ST_ANG: begin
        cmd.astep = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          cnt_nxt   = '0;
          state_nxt = acclt_pkg::ST_OUT;
        end
      end
      acclt_pkg::ST_OUT: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          cmd.oload = 1'b1;
          state_nxt = acclt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = acclt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.oload)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/acclt_datapath.sv -----
// Datapath: three filter lanes and three CORDIC lanes, output registers.
// Depends on acclt_pkg.
module acclt_datapath #(
  parameter int SAMPLE_BITS   = 14,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  acclt_pkg::cmd_t                        cmd,
  input  logic [acclt_pkg::ALPHA_W-1:0]          alpha,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_x,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_y,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_z,
  output logic signed [SAMPLE_BITS-1:0]          out_gravity_x,
  output logic signed [SAMPLE_BITS-1:0]          out_gravity_y,
  output logic signed [SAMPLE_BITS-1:0]          out_gravity_z,
  output logic signed [acclt_pkg::ANGLE_W-1:0]   out_angle_x,
  output logic signed [acclt_pkg::ANGLE_W-1:0]   out_angle_y,
  output logic signed [acclt_pkg::ANGLE_W-1:0]   out_angle_z,
  output logic                                   unused_ok
);

  localparam int ST_W = SAMPLE_BITS + FRACTION_BITS;
  localparam int D_W  = ST_W + 1;
  localparam int FP_W = D_W + acclt_pkg::ALPHA_W + 1;
  localparam int CW   = ST_W + 4;
  localparam int GP_W = CW + 17;
  localparam int ZW   = acclt_pkg::Z_W;
  localparam int AW   = acclt_pkg::ANGLE_W;

  localparam logic signed [FP_W-1:0] FP_HALF = FP_W'(32768);
  localparam logic signed [GP_W-1:0] GP_HALF = GP_W'(32768);
  localparam logic signed [ST_W:0]   G_HALF  = (ST_W+1)'(1) << (FRACTION_BITS - 1);
  localparam logic signed [ZW:0]     Z_HALF  = (ZW+1)'(128);
  localparam logic signed [ZW-8:0]   LIM_W   = (ZW-7)'(acclt_pkg::ANGLE_LIMIT);

  logic signed [SAMPLE_BITS-1:0] smp_r [3];
  logic signed [ST_W-1:0] st_r [3], st_nxt [3];
  logic signed [FP_W-1:0] fp_r [3], fp_nxt [3];
  logic signed [CW-1:0]   u_r [3], u_nxt [3], v_r [3], v_nxt [3];
  logic signed [GP_W-1:0] gp_r [3], gp_nxt [3];
  logic signed [ZW-1:0]   z_r [3], z_nxt [3];
  logic                   zr_r [3], zr_nxt [3];
  logic signed [ST_W-1:0] a_s [3], b_s [3], c_s [3];
  logic signed [SAMPLE_BITS-1:0] grav [3];
  logic signed [AW-1:0]   ang [3];

  // lane k: a = axis k, b and c = the other two
  always_comb begin
    a_s[0] = st_r[0]; b_s[0] = st_r[1]; c_s[0] = st_r[2];
    a_s[1] = st_r[1]; b_s[1] = st_r[0]; c_s[1] = st_r[2];
    a_s[2] = st_r[2]; b_s[2] = st_r[1]; c_s[2] = st_r[0];
  end

  always_comb begin
    logic signed [D_W-1:0]  d;
    logic signed [FP_W-1:0] fr;
    logic signed [GP_W-1:0] gr;
    logic signed [CW-1:0]   bx, cx, du, dv;
    logic signed [ZW-1:0]   tz;
    logic signed [ST_W:0]   gs;
    logic signed [ZW:0]     za;
    logic signed [ZW-8:0]   aw;
    for (int k = 0; k < 3; k++) begin
      st_nxt[k] = st_r[k];
      fp_nxt[k] = fp_r[k];
      u_nxt[k]  = u_r[k];
      v_nxt[k]  = v_r[k];
      gp_nxt[k] = gp_r[k];
      z_nxt[k]  = z_r[k];
      zr_nxt[k] = zr_r[k];

      d = {smp_r[k][SAMPLE_BITS-1], smp_r[k], {FRACTION_BITS{1'b0}}}
          - {st_r[k][ST_W-1], st_r[k]};
      if (cmd.fmul) fp_nxt[k] = d * $signed({1'b0, alpha});
      fr = fp_r[k] + FP_HALF;
      if (cmd.fupd) st_nxt[k] = st_r[k] + fr[ST_W+15:16];

      bx = CW'(b_s[k]);
      cx = CW'(c_s[k]);
      du = v_r[k] >>> cmd.step;
      dv = u_r[k] >>> cmd.step;
      tz = ZW'(acclt_pkg::ATAN_TAB[cmd.step]);
      if (cmd.minit) begin
        u_nxt[k]  = bx[CW-1] ? -bx : bx;
        v_nxt[k]  = cx[CW-1] ? -cx : cx;
        zr_nxt[k] = (b_s[k] == '0) && (c_s[k] == '0);
      end
      if (cmd.mstep || cmd.astep) begin
        if (!v_r[k][CW-1]) begin
          u_nxt[k] = u_r[k] + du;
          v_nxt[k] = v_r[k] - dv;
          if (cmd.astep) z_nxt[k] = z_r[k] + tz;
        end else begin
          u_nxt[k] = u_r[k] - du;
          v_nxt[k] = v_r[k] + dv;
          if (cmd.astep) z_nxt[k] = z_r[k] - tz;
        end
      end
      if (cmd.gmul) gp_nxt[k] = u_r[k] * acclt_pkg::INV_GAIN_Q16;
      gr = gp_r[k] + GP_HALF;
      if (cmd.ainit) begin
        u_nxt[k] = gr[CW+15:16];
        v_nxt[k] = CW'(a_s[k]);
        z_nxt[k] = '0;
      end

      gs = {st_r[k][ST_W-1], st_r[k]} + G_HALF;
      grav[k] = gs[FRACTION_BITS+SAMPLE_BITS-1:FRACTION_BITS];
      za = {z_r[k][ZW-1], z_r[k]} + Z_HALF;
      aw = za[ZW:8];
      if (zr_r[k]) begin
        if (a_s[k] == '0)        ang[k] = '0;
        else if (a_s[k][ST_W-1]) ang[k] = -acclt_pkg::ANGLE_LIMIT;
        else                     ang[k] = acclt_pkg::ANGLE_LIMIT;
      end else if (aw > LIM_W) ang[k] = acclt_pkg::ANGLE_LIMIT;
      else if (aw < -LIM_W)    ang[k] = -acclt_pkg::ANGLE_LIMIT;
      else                     ang[k] = aw[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp_r[0] <= in_sample_x;
      smp_r[1] <= in_sample_y;
      smp_r[2] <= in_sample_z;
    end
    for (int k = 0; k < 3; k++) begin
      fp_r[k] <= fp_nxt[k];
      u_r[k]  <= u_nxt[k];
      v_r[k]  <= v_nxt[k];
      gp_r[k] <= gp_nxt[k];
      z_r[k]  <= z_nxt[k];
      zr_r[k] <= zr_nxt[k];
    end
    if (cmd.oload) begin
      out_gravity_x <= grav[0];
      out_gravity_y <= grav[1];
      out_gravity_z <= grav[2];
      out_angle_x   <= ang[0];
      out_angle_y   <= ang[1];
      out_angle_z   <= ang[2];
    end
  end

  // filter state: the only datapath register that reset clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) st_r[k] <= '0;
    end else begin
      for (int k = 0; k < 3; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign unused_ok = 1'b1;

endmodule

// ----- rtl/acclt_checker.sv -----
// Port-level checks for the tilt-angle unit, bound to the top level.
// Depends on accel_lowpass_tilt_angles_unit.
module acclt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_angle_x,
  input logic signed [15:0] out_angle_y,
  input logic signed [15:0] out_angle_z
);

  // a stalled result stays put (checked on out_angle_x)
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle_x))
    else $error("output changed while stalled");

  // one sample at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // no result straight after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // angles never exceed +-90 degrees
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_x <= 16'sd23040) && (out_angle_x >= -16'sd23040)
                  && (out_angle_y <= 16'sd23040) && (out_angle_y >= -16'sd23040)
                  && (out_angle_z <= 16'sd23040) && (out_angle_z >= -16'sd23040))
    else $error("angle out of range");

endmodule

bind accel_lowpass_tilt_angles_unit acclt_checker u_acclt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_angle_x (out_angle_x),
  .out_angle_y (out_angle_y),
  .out_angle_z (out_angle_z)
);

// ----- dv/accel_lowpass_tilt_angles_unit_tb.sv -----
// Self-checking bench for accel_lowpass_tilt_angles_unit: directed table, then random samples,
// each result compared to an in-bench fixed-point filter and CORDIC tilt predictor or a typed-in row.
// Depends on acclt_pkg and the RTL of the unit.
module accel_lowpass_tilt_angles_unit_tb;

  localparam int SB = 14;
  localparam int FB = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [SB-1:0] gx, gy, gz;
    logic signed [15:0]   ax, ay, az;
  } tilt_res_t;

  // one directed row; chk means the expected value is typed in the row
  typedef struct {
    logic signed [SB-1:0] sx, sy, sz;
    logic                 chk;
    tilt_res_t            res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0;
  logic signed [SB-1:0] in_sample_x = '0, in_sample_y = '0, in_sample_z = '0;
  logic out_valid, in_ready;
  logic signed [SB-1:0] out_gravity_x, out_gravity_y, out_gravity_z;
  logic signed [15:0] out_angle_x, out_angle_y, out_angle_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #2 clk = ~clk;

  accel_lowpass_tilt_angles_unit u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample_x, .in_sample_y, .in_sample_z,
    .out_valid, .out_ready, .out_gravity_x, .out_gravity_y, .out_gravity_z,
    .out_angle_x, .out_angle_y, .out_angle_z,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state: filter accumulators and the coefficient copy.
  logic signed [SB+FB-1:0] ema_acc [3];
  logic [15:0] alpha_q16;
  tilt_res_t pending_tilt [$];
  tilt_res_t row_override [$];   // typed-in expectations, parallel to pending_tilt
  logic      row_has_override [$];

  int errors = 0;
  int n_sent = 0, n_got = 0;
  int idle_tx_pct = 0, idle_rx_pct = 0;
  bit rx_hold = 1'b0;
  int quiet_cycles = 0;

  function automatic longint fl_shr(longint v, int n);
    return v >>> n;   // arithmetic shift is floor on longint
  endfunction

  // |(b,c)| through CORDIC vectoring, then gain removal
  function automatic longint cordic_mag(longint b, longint c);
    longint u, v, du, dv;
    u = b < 0 ? -b : b;
    v = c < 0 ? -c : c;
    for (int i = 0; i < acclt_pkg::CORDIC_STEPS; i++) begin
      du = fl_shr(v, i);
      dv = fl_shr(u, i);
      if (v >= 0) begin
        u += du; v -= dv;
      end else begin
        u -= du; v += dv;
      end
    end
    return fl_shr(u * longint'(acclt_pkg::INV_GAIN_Q16) + 32768, 16);
  endfunction

  function automatic logic signed [15:0] tilt_of(longint a, longint b, longint c);
    longint x, y, z, dx, dy, ang;
    if (b == 0 && c == 0) begin
      // other two axes zero: straight up, down, or flat
      return a > 0 ? acclt_pkg::ANGLE_LIMIT
                   : (a < 0 ? -acclt_pkg::ANGLE_LIMIT : 16'sd0);
    end
    x = cordic_mag(b, c);
    y = a;
    z = 0;
    for (int i = 0; i < acclt_pkg::CORDIC_STEPS; i++) begin
      dx = fl_shr(y, i);
      dy = fl_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(acclt_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(acclt_pkg::ATAN_TAB[i]);
      end
    end
    ang = fl_shr(z + 128, 8);
    if (ang > 23040) ang = 23040;
    if (ang < -23040) ang = -23040;
    return ang[15:0];
  endfunction

  // Advance the filter for one sample and produce the expected result.
  function automatic tilt_res_t filter_and_tilt(logic signed [SB-1:0] sx, sy, sz);
    tilt_res_t r;
    longint s [3];
    longint d, g [3];
    s[0] = sx; s[1] = sy; s[2] = sz;
    for (int k = 0; k < 3; k++) begin
      d = (s[k] <<< FB) - longint'(ema_acc[k]);
      ema_acc[k] = (SB+FB)'(longint'(ema_acc[k])
                            + fl_shr(d * longint'({1'b0, alpha_q16}) + 32768, 16));
    end
    for (int k = 0; k < 3; k++) g[k] = fl_shr(longint'(ema_acc[k]) + (1 << (FB - 1)), FB);
    r.gx = g[0][SB-1:0]; r.gy = g[1][SB-1:0]; r.gz = g[2][SB-1:0];
    r.ax = tilt_of(ema_acc[0], ema_acc[1], ema_acc[2]);
    r.ay = tilt_of(ema_acc[1], ema_acc[0], ema_acc[2]);
    r.az = tilt_of(ema_acc[2], ema_acc[1], ema_acc[0]);
    return r;
  endfunction

  // APB write, two-phase, then a read-back; the block is idle whenever this is called.
  task automatic write_alpha(logic [15:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = 3'(acclt_pkg::REG_ALPHA) << 2; pwdata = {16'd0, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    alpha_q16 = val;
    // read back for a sanity check of the register
    @(negedge clk);
    psel = 1'b1; paddr = 3'(acclt_pkg::REG_ALPHA) << 2;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== val) begin
      $error("alpha readback: expected %0d actual %0d", val, prdata[15:0]);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  // Offer one sample; valid stays up until the transfer, gaps at random.
  task automatic send_sample(logic signed [SB-1:0] sx, sy, sz, bit chk, tilt_res_t typed);
    tilt_res_t exp_r;
    while (idle_tx_pct != 0 && $urandom_range(99) < idle_tx_pct) @(negedge clk);
    in_valid = 1'b1; in_sample_x = sx; in_sample_y = sy; in_sample_z = sz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_r = filter_and_tilt(sx, sy, sz);
    pending_tilt.push_back(exp_r);
    row_override.push_back(typed);
    row_has_override.push_back(chk);
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for all results, then leave at a falling edge so driving stays aligned.
  task automatic drain(int settle);
    int guard;
    guard = 0;
    while (pending_tilt.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [SB-1:0] rnd_sample();
    case ($urandom_range(9))
      0: return -14'sd8192;
      1: return 14'sd8191;
      2: return 14'sd0;
      3: return SB'($signed($urandom_range(15)) - 8);
      default: return SB'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off requested by the stimulus.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !rx_hold && !(idle_rx_pct != 0 && $urandom_range(99) < idle_rx_pct);
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    tilt_res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_got++;
      if (pending_tilt.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = pending_tilt.pop_front();
        // typed-in rows are checked against their own expected values
        if (row_has_override.pop_front()) e = row_override[0];
        void'(row_override.pop_front());
        if (out_gravity_x !== e.gx) begin
          $error("gravity_x: expected %0d actual %0d", e.gx, out_gravity_x); errors++;
        end
        if (out_gravity_y !== e.gy) begin
          $error("gravity_y: expected %0d actual %0d", e.gy, out_gravity_y); errors++;
        end
        if (out_gravity_z !== e.gz) begin
          $error("gravity_z: expected %0d actual %0d", e.gz, out_gravity_z); errors++;
        end
        if (out_angle_x !== e.ax) begin
          $error("angle_x: expected %0d actual %0d", e.ax, out_angle_x); errors++;
        end
        if (out_angle_y !== e.ay) begin
          $error("angle_y: expected %0d actual %0d", e.ay, out_angle_y); errors++;
        end
        if (out_angle_z !== e.az) begin
          $error("angle_z: expected %0d actual %0d", e.az, out_angle_z); errors++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel or any APB access.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Directed table; a zero-state row after reset has a typed expectation.
  stim_row_t dir_rows [$];
  tilt_res_t none_r;

  initial begin
    stim_row_t row;
    logic [15:0] alphas [5];
    alphas = '{16'd65535, 16'd0, 16'd1, 16'd32768, 16'd12000};
    none_r = '{default: '0};
    ema_acc = '{default: '0};
    alpha_q16 = acclt_pkg::ALPHA_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all zero right after reset: gravity 0, every angle flat
    row = '{sx: 0, sy: 0, sz: 0, chk: 1'b1, res: '{default: '0}};
    dir_rows.push_back(row);
    row = '{sx: 0, sy: 0, sz: 14'sd8191, chk: 1'b0, res: none_r}; dir_rows.push_back(row);
    row = '{sx: -14'sd8192, sy: 0, sz: 0, chk: 1'b0, res: none_r}; dir_rows.push_back(row);
    row = '{sx: 14'sd8191, sy: 14'sd8191, sz: 14'sd8191, chk: 1'b0, res: none_r};
    dir_rows.push_back(row);
    row = '{sx: -14'sd8192, sy: -14'sd8192, sz: -14'sd8192, chk: 1'b0, res: none_r};
    dir_rows.push_back(row);
    row = '{sx: 14'sd1, sy: -14'sd1, sz: 14'sd0, chk: 1'b0, res: none_r};
    dir_rows.push_back(row);
    row = '{sx: 14'sd100, sy: 14'sd0, sz: -14'sd4096, chk: 1'b0, res: none_r};
    dir_rows.push_back(row);
    row = '{sx: 14'sd0, sy: 14'sd0, sz: 14'sd0, chk: 1'b0, res: none_r};
    dir_rows.push_back(row);

    // phase A: sender gaps 19%, receiver 55%
    idle_tx_pct = 19; idle_rx_pct = 55;
    foreach (dir_rows[i]) send_sample(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].sz,
                                      dir_rows[i].chk, dir_rows[i].res);
    drain(80);

    // coefficient sweep incl. extremes; zero coefficient freezes the state
    foreach (alphas[j]) begin
      write_alpha(alphas[j]);
      for (int i = 0; i < 6; i++) send_sample(rnd_sample(), rnd_sample(), rnd_sample(),
                                              1'b0, none_r);
      drain(80);
    end
    write_alpha(acclt_pkg::ALPHA_RESET);

    // long receiver hold-off while samples keep coming
    fork
      begin
        rx_hold = 1'b1;
        repeat (600) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 4; i++) send_sample(rnd_sample(), rnd_sample(), rnd_sample(),
                                              1'b0, none_r);
    join
    drain(80);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin idle_tx_pct = 19; idle_rx_pct = 55; end
        1: begin idle_tx_pct = 55; idle_rx_pct = 19; end
        default: begin idle_tx_pct = 0; idle_rx_pct = 0; end
      endcase
      if (ph == 1) begin
        write_alpha(16'($urandom));
      end
      for (int i = 0; i < 560; i++) send_sample(rnd_sample(), rnd_sample(), rnd_sample(),
                                                1'b0, none_r);
      drain(0);
    end
    drain(80);

    $display("Covered %0d samples, %0d results, coefficient extremes and a long output stall.",
             n_sent, n_got);
    if (errors == 0 && pending_tilt.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (pending_tilt.size() != 0) $error("%0d results never arrived", pending_tilt.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
